### rtl/core/kce_pkg.sv
// ----------------------------------------------------------------------------
// kce_pkg
// Shared types, constants and key decode for the console keypad.
// ----------------------------------------------------------------------------
package kce_pkg;

   localparam int unsigned MAX_DIGITS_DEF = 8;
   localparam int unsigned QUEUE_DEPTH    = 2;

   localparam logic [31:0] ADDR_RESET   = 32'h0000_C000;
   localparam logic [31:0] DATA_RESET   = 32'h0000_0024;
   localparam logic [31:0] STATUS_RESET = 32'h0000_0055;

   localparam logic [7:0] DOT_ADDR = 8'h80;
   localparam logic [7:0] DOT_DATA = 8'h40;
   localparam logic [7:0] DOT_NONE = 8'h00;

   typedef enum logic [1:0] {
      DISP_BUFFER = 2'd0,
      DISP_ADDR   = 2'd1,
      DISP_DATA   = 2'd2
   } disp_type;

   typedef enum logic [3:0] {
      OP_DIGIT,
      OP_CLEAR,
      OP_ERASE,
      OP_SHOW_ADDR,
      OP_SHOW_DATA,
      OP_LOAD_DATA,
      OP_LOAD_ADDR,
      OP_LOAD_STATUS,
      OP_SHOW_BUF
   } op_type;

   typedef struct packed {
      op_type     op;
      logic [2:0] digit;
   } cmd_type;

   typedef struct packed {
      logic [3:0] digit_count;
   } back_status_type;

   function automatic cmd_type key_of_bit(input logic [3:0] b);
      cmd_type c;
      c.op    = OP_DIGIT;
      c.digit = 3'd0;
      case (b)
         4'd0:  c.op = OP_SHOW_ADDR;
         4'd1:  c.digit = 3'd7;
         4'd2:  c.op = OP_SHOW_DATA;
         4'd3:  c.op = OP_LOAD_DATA;
         4'd4:  c.op = OP_LOAD_ADDR;
         4'd5:  c.digit = 3'd4;
         4'd6:  c.digit = 3'd5;
         4'd7:  c.digit = 3'd6;
         4'd8:  c.op = OP_LOAD_STATUS;
         4'd9:  c.digit = 3'd1;
         4'd10: c.digit = 3'd2;
         4'd11: c.digit = 3'd3;
         4'd12: c.op = OP_CLEAR;
         4'd13: c.digit = 3'd0;
         4'd14: c.op = OP_SHOW_BUF;
         4'd15: c.op = OP_ERASE;
         default: c.op = OP_SHOW_BUF;
      endcase
      return c;
   endfunction

endpackage

### rtl/core/kce_front.sv
// ----------------------------------------------------------------------------
// kce_front
// Edge detect on the polled button word and key classification.
// ----------------------------------------------------------------------------
module kce_front import kce_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        accept,
   input  logic [15:0] buttons,
   output logic        push,
   output cmd_type     cmd
);

   logic [15:0] last_buttons_ff;
   logic        one_hot;
   logic [3:0]  bit_idx;

   always_comb begin
      bit_idx = 4'd0;
      for (int b = 0; b < 16; b++) begin
         if (buttons[b]) begin
            bit_idx = 4'(b);
         end
      end
   end

   assign one_hot = (buttons != 16'd0) && ((buttons & (buttons - 16'd1)) == 16'd0);
   assign push    = accept && (buttons != 16'd0) && (buttons != last_buttons_ff);

   always_comb begin
      if (one_hot) begin
         cmd = key_of_bit(bit_idx);
      end else begin
         cmd.op    = OP_SHOW_BUF;
         cmd.digit = 3'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_buttons_ff <= 16'd0;
      end else if (accept) begin
         last_buttons_ff <= buttons;
      end
   end

endmodule

### rtl/core/kce_queue.sv
// ----------------------------------------------------------------------------
// kce_queue
// Two-entry command queue between the front and back parts.
// ----------------------------------------------------------------------------
module kce_queue import kce_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   input  logic    pop,
   output logic    full,
   output logic    not_empty,
   output cmd_type head,
   output logic [1:0] level
);

   cmd_type    mem_ff [QUEUE_DEPTH];
   logic       wr_ptr_ff;
   logic       rd_ptr_ff;
   logic [1:0] count_ff;
   logic [1:0] count_in;

   assign full      = (count_ff == 2'(QUEUE_DEPTH));
   assign not_empty = (count_ff != 2'd0);
   assign head      = mem_ff[rd_ptr_ff];
   assign level     = count_ff;

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
         count_ff <= count_in;
      end
   end

endmodule

### rtl/core/kce_back.sv
// ----------------------------------------------------------------------------
// kce_back
// Digit buffer, console registers and the registered display word.
// ----------------------------------------------------------------------------
module kce_back import kce_pkg::*; #(
   parameter int unsigned MAX_DIGITS = MAX_DIGITS_DEF
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            cmd_valid,
   input  cmd_type         cmd,
   output logic            pop,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output logic [1:0]      rsp_display_kind,
   output logic [31:0]     rsp_shown_value,
   output logic [3:0]      rsp_shown_digits,
   output logic [7:0]      rsp_dot_mask,
   output back_status_type status
);

   localparam logic [3:0] MAX_CNT = 4'(MAX_DIGITS);

   // buffer digits packed, last digit lowest; bits above count*4 stay zero
   logic [31:0] buf_ff, buf_in;
   logic [3:0]  count_ff, count_in;
   logic [31:0] addr_ff, addr_in;
   logic [31:0] data_ff, data_in;
   logic [31:0] status_ff, status_in;
   logic        out_valid_ff, out_valid_in;
   disp_type    kind_ff, kind_in;
   logic [31:0] value_ff, value_in;
   logic [3:0]  digits_ff, digits_in;
   logic [7:0]  dots_ff, dots_in;
   logic        emit;

   assign pop = cmd_valid && (!out_valid_ff || rsp_ready);

   always_comb begin
      buf_in    = buf_ff;
      count_in  = count_ff;
      addr_in   = addr_ff;
      data_in   = data_ff;
      status_in = status_ff;
      emit      = 1'b0;
      kind_in   = DISP_BUFFER;
      value_in  = 32'd0;
      digits_in = 4'd0;
      dots_in   = DOT_NONE;
      if (pop) begin
         emit = 1'b1;
         case (cmd.op)
            OP_DIGIT: begin
               if (count_ff < MAX_CNT) begin
                  buf_in   = {buf_ff[27:0], 1'b0, cmd.digit};
                  count_in = count_ff + 4'd1;
               end
            end
            OP_CLEAR: begin
               buf_in   = 32'd0;
               count_in = 4'd0;
            end
            OP_ERASE: begin
               if (count_ff != 4'd0) begin
                  buf_in   = {4'd0, buf_ff[31:4]};
                  count_in = count_ff - 4'd1;
               end
            end
            OP_LOAD_DATA: begin
               data_in = buf_ff;
               emit    = 1'b0;
            end
            OP_LOAD_ADDR: begin
               addr_in = buf_ff;
               emit    = 1'b0;
            end
            OP_LOAD_STATUS: begin
               status_in = buf_ff;
               emit      = 1'b0;
            end
            default: begin
            end
         endcase
         case (cmd.op)
            OP_SHOW_ADDR: begin
               kind_in  = DISP_ADDR;
               value_in = addr_ff;
               dots_in  = DOT_ADDR;
            end
            OP_SHOW_DATA: begin
               kind_in  = DISP_DATA;
               value_in = data_ff;
               dots_in  = DOT_DATA;
            end
            default: begin
               value_in  = buf_in;
               digits_in = count_in;
            end
         endcase
      end
      out_valid_in = emit || (out_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         buf_ff       <= 32'd0;
         count_ff     <= 4'd0;
         addr_ff      <= ADDR_RESET;
         data_ff      <= DATA_RESET;
         status_ff    <= STATUS_RESET;
         out_valid_ff <= 1'b0;
      end else begin
         buf_ff       <= buf_in;
         count_ff     <= count_in;
         addr_ff      <= addr_in;
         data_ff      <= data_in;
         status_ff    <= status_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         kind_ff   <= kind_in;
         value_ff  <= value_in;
         digits_ff <= digits_in;
         dots_ff   <= dots_in;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_display_kind   = kind_ff;
   assign rsp_shown_value    = value_ff;
   assign rsp_shown_digits   = digits_ff;
   assign rsp_dot_mask       = dots_ff;
   assign status.digit_count = count_ff;

endmodule

### rtl/core/keypad_console_entry_top.sv
// ----------------------------------------------------------------------------
// keypad_console_entry_top
// Path: an accepted poll whose nonzero word differs from the last is queued as
// a command, and the back part then registers its display word (none for loads).
// Throughput: one poll per cycle; the command queue and output register
// keep it there while rsp_ready is high.
// Reset: synchronous; buffer empty, address 0xC000, data 0x24, status 0x55.
// ----------------------------------------------------------------------------
module keypad_console_entry_top import kce_pkg::*; #(
   parameter int unsigned MAX_DIGITS = MAX_DIGITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [15:0] req_buttons,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_display_kind,
   output logic [31:0] rsp_shown_value,
   output logic [3:0]  rsp_shown_digits,
   output logic [7:0]  rsp_dot_mask
);

   logic            accept;
   logic            push;
   cmd_type         push_cmd;
   logic            full;
   logic            not_empty;
   cmd_type         head;
   logic            pop;
   logic [1:0]      level;
   back_status_type back_status;

   assign req_ready = !full;
   assign accept    = req_valid && req_ready;

   kce_front u_front (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .buttons (req_buttons),
      .push    (push),
      .cmd     (push_cmd)
   );

   kce_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_cmd  (push_cmd),
      .pop       (pop),
      .full      (full),
      .not_empty (not_empty),
      .head      (head),
      .level     (level)
   );

   kce_back #(.MAX_DIGITS(MAX_DIGITS)) u_back (
      .clock            (clock),
      .reset            (reset),
      .cmd_valid        (not_empty),
      .cmd              (head),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_display_kind (rsp_display_kind),
      .rsp_shown_value  (rsp_shown_value),
      .rsp_shown_digits (rsp_shown_digits),
      .rsp_dot_mask     (rsp_dot_mask),
      .status           (back_status)
   );

   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      back_status.digit_count <= 4'(MAX_DIGITS))
      else $error("digit count beyond limit");

   a_queue_bound : assert property (@(posedge clock) disable iff (reset)
      level <= 2'(QUEUE_DEPTH))
      else $error("command queue overfilled");

   a_reg_display : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_display_kind != DISP_BUFFER) |->
         (rsp_shown_digits == 4'd0) && (rsp_dot_mask != DOT_NONE))
      else $error("register display with digits or without dot");

   a_no_pop_empty : assert property (@(posedge clock) disable iff (reset)
      pop |-> not_empty)
      else $error("pop from empty queue");

endmodule
